// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked on clk and held off
// while rst is high. Defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant violated");

// A condition that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check violated");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Sizes, codes and control/status bundles shared by the deadline timer
// queue modules.
// ----------------------------------------------------------------------------
package dtq_pkg;

  // Number of timer slots held by the queue.
  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // Fixed field widths.
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int TIME_W  = 64;
  localparam int STAMP_W = 32;
  localparam int KIND_W  = 2;

  // Width of one stored slot entry: deadline above registration stamp.
  localparam int ENTRY_W = TIME_W + STAMP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRE  = 2'd0,
    KIND_ALARM = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the input beat
    logic arm;          // write the entry for the requested slot and queue it
    logic disarm_slot;  // dequeue the requested slot
    logic disarm_best;  // dequeue the earliest slot found by the last scan
    logic scan_start;   // begin a pass over all slots
    logic emit_fire;    // present an expiry result
    logic emit_report;  // present the final alarm or clear result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             slot_ok;
    logic             slot_queued;
    logic             scan_done;
    logic             best_valid;
    logic             best_expired;
    logic             fired_any;
  } dp_status_t;

endpackage

// ===== src/dtq_ram.sv =====
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dtq_datapath.sv =====
// ----------------------------------------------------------------------------
// dtq_datapath
// Captured input beat, queued flags, slot entry memory, the scan that finds
// the earliest deadline, and the result registers.
// ----------------------------------------------------------------------------
module dtq_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dtq_pkg::CMD_W-1:0]  cmd,
  input  logic [dtq_pkg::SLOT_W-1:0] slot,
  input  logic [dtq_pkg::TIME_W-1:0] delay_ns,
  input  logic [dtq_pkg::TIME_W-1:0] now,
  input  dtq_pkg::ctrl_cmd_t         ctl,
  output dtq_pkg::dp_status_t        st,
  output logic                       valid,
  output logic [dtq_pkg::KIND_W-1:0] kind,
  output logic [dtq_pkg::SLOT_W-1:0] fired_slot,
  output logic [dtq_pkg::TIME_W-1:0] alarm_delay,
  output logic                       last
);

  import dtq_pkg::*;

  // Captured beat.
  logic [CMD_W-1:0]   cmd_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TIME_W-1:0]  delay_q;
  logic [TIME_W-1:0]  now_q;

  logic [SLOTS-1:0]   queued;
  logic [STAMP_W-1:0] stamp_ctr;
  logic [IDX_W-1:0]   slot_idx;

  // Scan sequencing.
  logic               scan_active;
  logic [CNT_W-1:0]   cnt;
  logic               issuing;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  logic               scan_done;

  // Running minimum.
  logic               best_valid;
  logic [IDX_W-1:0]   best_idx;
  logic [TIME_W-1:0]  best_dl;
  logic [STAMP_W-1:0] best_stamp;
  logic               best_expired;
  logic               fired_any;

  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [TIME_W-1:0]  rd_dl;
  logic [STAMP_W-1:0] rd_stamp;
  logic               cand_better;

  kind_t              kind_q;

  assign slot_idx = IDX_W'(slot_q);
  assign wdata    = {now_q + delay_q, stamp_ctr};
  assign issuing  = scan_active && (cnt < CNT_W'(SLOTS));
  assign scan_done = scan_active && !issuing && !rd_en;

  dtq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entries (
    .clk   (clk),
    .we    (ctl.arm),
    .waddr (slot_idx),
    .wdata (wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign rd_dl    = rdata[ENTRY_W-1:STAMP_W];
  assign rd_stamp = rdata[STAMP_W-1:0];

  // Earlier deadline wins; on a tie the newer registration wins, and on equal
  // stamps the lower index already held is kept.
  assign cand_better = queued[rd_idx] &&
                       (!best_valid || (rd_dl < best_dl) ||
                        ((rd_dl == best_dl) && (rd_stamp > best_stamp)));

  assign best_expired = best_dl <= now_q;

  always_comb begin
    st              = '0;
    st.cmd          = cmd_q;
    st.slot_ok      = 32'(slot_q) < SLOTS;
    st.slot_queued  = queued[slot_idx];
    st.scan_done    = scan_done;
    st.best_valid   = best_valid;
    st.best_expired = best_expired;
    st.fired_any    = fired_any;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      queued      <= '0;
      stamp_ctr   <= '0;
      scan_active <= 1'b0;
      rd_en       <= 1'b0;
      fired_any   <= 1'b0;
      best_valid  <= 1'b0;
      cnt         <= '0;
      valid       <= 1'b0;
    end else begin
      rd_en <= issuing && !ctl.scan_start;
      valid <= ctl.emit_fire || ctl.emit_report;
      if (ctl.load) begin
        fired_any <= 1'b0;
      end
      if (ctl.emit_fire) begin
        fired_any <= 1'b1;
      end
      if (ctl.arm) begin
        queued[slot_idx] <= 1'b1;
        stamp_ctr        <= stamp_ctr + 1'b1;
      end
      if (ctl.disarm_slot) begin
        queued[slot_idx] <= 1'b0;
      end
      if (ctl.disarm_best) begin
        queued[best_idx] <= 1'b0;
      end
      if (ctl.scan_start) begin
        scan_active <= 1'b1;
        cnt         <= '0;
        best_valid  <= 1'b0;
      end else begin
        if (issuing) begin
          cnt <= cnt + 1'b1;
        end
        if (scan_done) begin
          scan_active <= 1'b0;
        end
        if (rd_en && cand_better) begin
          best_valid <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= cmd;
      slot_q  <= slot;
      delay_q <= delay_ns;
      now_q   <= now;
    end
    rd_idx <= cnt[IDX_W-1:0];
    if (!ctl.scan_start && rd_en && cand_better) begin
      best_idx   <= rd_idx;
      best_dl    <= rd_dl;
      best_stamp <= rd_stamp;
    end
    if (ctl.emit_fire) begin
      kind_q      <= KIND_FIRE;
      fired_slot  <= SLOT_W'(best_idx);
      alarm_delay <= '0;
      last        <= 1'b0;
    end else if (ctl.emit_report) begin
      fired_slot <= '0;
      last       <= 1'b1;
      if (best_valid) begin
        kind_q      <= KIND_ALARM;
        alarm_delay <= best_expired ? '0 : best_dl - now_q;
      end else begin
        kind_q      <= KIND_CLEAR;
        alarm_delay <= '0;
      end
    end
  end

  assign kind = kind_q;

endmodule

// ===== src/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer for the deadline timer queue: decodes the captured beat, runs
// scans and decides between firing a slot and the final report.
// ----------------------------------------------------------------------------
module dtq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dtq_pkg::dp_status_t st,
  output dtq_pkg::ctrl_cmd_t  ctl
);

  import dtq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        unique case (st.cmd)
          CMD_TICK: begin
            ctl.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
          CMD_ARM: begin
            if (st.slot_ok && !st.slot_queued) begin
              ctl.arm        = 1'b1;
              ctl.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          CMD_REMOVE: begin
            if (st.slot_ok && st.slot_queued) begin
              ctl.disarm_slot = 1'b1;
              ctl.scan_start  = 1'b1;
              state_next      = ST_SCAN;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (st.scan_done) begin
          if ((st.cmd == CMD_TICK) && st.best_valid && st.best_expired) begin
            // Fire the earliest slot and rescan for the next one.
            ctl.emit_fire   = 1'b1;
            ctl.disarm_best = 1'b1;
            ctl.scan_start  = 1'b1;
          end else begin
            state_next = ST_IDLE;
            if ((st.cmd != CMD_TICK) || st.fired_any) begin
              ctl.emit_report = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Sorted queue of one-shot timers with alarm reporting.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; busy stays high
// until every result of that beat has been presented. Results appear on kind,
// fired_slot, alarm_delay and last for exactly one cycle, marked by valid,
// and must be captured in that cycle: the block cannot be stalled. Each pass
// over the slot memory reads one slot per cycle through the single read port
// of the entry memory. A register or remove beat gives its single result
// after one pass; a tick that fires k slots runs a further pass after each
// expiry, and a tick that fires nothing ends after one pass with no result.
// A new beat may be accepted in the cycle in which the final result is shown.
//
// Register (cmd 1) arms the slot at now + delay_ns unless it is already
// armed; remove (cmd 2) disarms an armed slot. Either then reports the time
// to the earliest deadline (kind 1) or an alarm clear (kind 2) when the queue
// is empty. Tick (cmd 0) fires every slot with a deadline at or before now,
// earliest first and newest registration first on equal deadlines, each as a
// kind 0 beat, and then the alarm or clear beat. The last flag marks the
// final beat of a command. Alarm delays that would be negative read as zero.
// Deadlines wrap modulo 2^64. Commands that do nothing give no result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deadline_timer_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [dtq_pkg::CMD_W-1:0]  cmd,
  input  logic [dtq_pkg::SLOT_W-1:0] slot,
  input  logic [dtq_pkg::TIME_W-1:0] delay_ns,
  input  logic [dtq_pkg::TIME_W-1:0] now,
  output logic                       valid,
  output logic [dtq_pkg::KIND_W-1:0] kind,
  output logic [dtq_pkg::SLOT_W-1:0] fired_slot,
  output logic [dtq_pkg::TIME_W-1:0] alarm_delay,
  output logic                       last
);

  import dtq_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  ctrl_cmd_t  ctl;
  dp_status_t st;

  // The sequencer owns busy and decides, after each scan, whether the
  // earliest slot fires or the final report goes out.
  dtq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  // The datapath holds the slot entries and queued flags, runs the scan for
  // the earliest deadline and registers every result beat.
  dtq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .slot        (slot),
    .delay_ns    (delay_ns),
    .now         (now),
    .ctl         (ctl),
    .st          (st),
    .valid       (valid),
    .kind        (kind),
    .fired_slot  (fired_slot),
    .alarm_delay (alarm_delay),
    .last        (last)
  );

  // An expiry beat is never the final one of its command.
  `ASSERT_ALWAYS(a_fire_not_last, !(valid && (kind == KIND_FIRE)) || !last)

  // Alarm and clear beats always close their command.
  `ASSERT_ALWAYS(a_report_is_last,
                 !(valid && ((kind == KIND_ALARM) || (kind == KIND_CLEAR))) || last)

  // After a beat that is not final, the block keeps working on the command.
  `ASSERT_NEXT(a_more_after_fire, valid && !last, busy)

  // While a command is being worked on no result comes from a fresh start.
  `ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !valid)

endmodule

// ===== verif/deadline_timer_queue_test.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_test
// Self-checking bench for the sorted deadline timer queue. Command beats
// (tick, register, remove and the unused code) are sent through the
// start/busy handshake. A scoreboard keeps its own copy of the slot
// deadlines, registration order and armed flags and predicts every expiry,
// alarm and clear beat. Each result strobe is checked field by field.
// ----------------------------------------------------------------------------
module deadline_timer_queue_test;
  import dtq_pkg::*;

  // The fourth command code has no meaning and must be dropped silently.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Run stops here even if the block hangs. The slowest legal command is a
  // tick that fires all slots: 17 scan passes, one per expiry and one more.
  localparam int CYCLE_LIMIT = 600_000;

  // Number of command beats sent over the whole run, directed part included.
  localparam int TOTAL_BEATS = 130;

  // Quiet cycles allowed after the last result; covers a tick that fires
  // nothing, which still takes a full scan pass.
  localparam int DRAIN_CYCLES = 3 * (SLOTS + 2);

  typedef struct {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  delay;
    logic               last;
  } timer_event_t;

  // Scoreboard: tracks the timer queue state and the results still owed.
  class deadline_tracker;
    logic [TIME_W-1:0]  due[SLOTS];
    bit                 armed[SLOTS];
    bit [STAMP_W-1:0]   stamp[SLOTS];
    bit [STAMP_W-1:0]   next_stamp;
    timer_event_t       pending[$];
    int                 errors;
    int                 checked;
    int                 expiries;

    // Slot at the head of the queue: earliest deadline, newest on a tie.
    function int head_slot();
      int best = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (armed[i] && (best < 0 || due[i] < due[best] ||
                         (due[i] == due[best] && stamp[i] > stamp[best])))
          best = i;
      end
      return best;
    endfunction

    function void owe(kind_t k, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] d,
                      logic l);
      timer_event_t ev;
      ev.kind  = k;
      ev.slot  = s;
      ev.delay = d;
      ev.last  = l;
      pending.push_back(ev);
    endfunction

    // Final beat of a command: time left to the head deadline, or a clear.
    function void owe_alarm(logic [TIME_W-1:0] t);
      int h;
      h = head_slot();
      if (h < 0)
        owe(KIND_CLEAR, '0, '0, 1'b1);
      else
        owe(KIND_ALARM, '0, (due[h] > t) ? due[h] - t : '0, 1'b1);
    endfunction

    // Applies one accepted command beat; returns how many results it owes.
    function int note_command(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                              logic [TIME_W-1:0] d, logic [TIME_W-1:0] t);
      int n = 0;
      int h;
      case (c)
        CMD_TICK: begin
          forever begin
            h = head_slot();
            if (h < 0 || due[h] > t)
              break;
            armed[h] = 1'b0;
            owe(KIND_FIRE, SLOT_W'(h), '0, 1'b0);
            n++;
          end
          if (n == 0)
            return 0;
          owe_alarm(t);
          return n + 1;
        end
        CMD_ARM: begin
          if (int'(s) >= SLOTS || armed[s])
            return 0;
          due[s]   = t + d;
          stamp[s] = next_stamp;
          next_stamp++;
          armed[s] = 1'b1;
          owe_alarm(t);
          return 1;
        end
        CMD_REMOVE: begin
          if (int'(s) >= SLOTS || !armed[s])
            return 0;
          armed[s] = 1'b0;
          owe_alarm(t);
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    // Compares one result beat with the oldest one still owed.
    function void check_result(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                               logic [TIME_W-1:0] d, logic l);
      timer_event_t ev;
      if (pending.size() == 0) begin
        $error("result beat with nothing owed: kind %0d slot %0d delay %0d last %0d",
               k, s, d, l);
        errors++;
        return;
      end
      ev = pending.pop_front();
      checked++;
      if (ev.kind == KIND_FIRE)
        expiries++;
      if (k !== ev.kind) begin
        $error("kind: expected %0d, got %0d", ev.kind, k);
        errors++;
      end
      if (s !== ev.slot) begin
        $error("fired_slot: expected %0d, got %0d", ev.slot, s);
        errors++;
      end
      if (d !== ev.delay) begin
        $error("alarm_delay: expected %0d, got %0d", ev.delay, d);
        errors++;
      end
      if (l !== ev.last) begin
        $error("last: expected %0d, got %0d", ev.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_W-1:0]   slot;
  logic [TIME_W-1:0]   delay_ns;
  logic [TIME_W-1:0]   now;
  logic                valid;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   fired_slot;
  logic [TIME_W-1:0]   alarm_delay;
  logic                last;

  deadline_tracker     tracker;
  int                  cycles;
  int                  beats_sent;
  int                  busy_beats;   // beats that owed at least one result
  logic [TIME_W-1:0]   wall_time;    // well-formed traffic moves forward in time

  deadline_timer_queue uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .slot        (slot),
    .delay_ns    (delay_ns),
    .now         (now),
    .valid       (valid),
    .kind        (kind),
    .fired_slot  (fired_slot),
    .alarm_delay (alarm_delay),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result monitor. The block cannot be stalled, so every strobe is taken.
  // Outputs are read at the edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && valid)
      tracker.check_result(kind, fired_slot, alarm_delay, last);
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom(), $urandom()};
  endfunction

  // Idle cycles between beats: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Sends one command beat. Called just after a rising edge; returns just
  // after the edge that accepted the beat, or after the idle gap that
  // follows it. With no gap, start stays high for the next beat.
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                           input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] t);
    int gap;
    start    <= 1'b1;
    cmd      <= c;
    slot     <= s;
    delay_ns <= d;
    now      <= t;
    do
      @(posedge clk);
    while (busy);
    beats_sent++;
    if (tracker.note_command(c, s, d, t) > 0)
      busy_beats++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (tracker.pending.size() != 0)
      @(posedge clk);
  endtask

  // One random beat. Most are well-formed traffic on a forward-moving
  // clock with short delays, so deadlines actually expire and tie up;
  // the rest are noise with full-range times, delays and command codes.
  task automatic random_beat();
    logic [CMD_W-1:0]  c;
    logic [SLOT_W-1:0] s;
    logic [TIME_W-1:0] d;
    int                r;
    int                pick;
    r = $urandom_range(0, 99);
    s = SLOT_W'($urandom_range(0, SLOTS - 1));
    if (r < 88) begin
      wall_time = wall_time + $urandom_range(0, 150);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        c = CMD_ARM;
        d = ($urandom_range(0, 9) == 0) ? '0 : TIME_W'($urandom_range(1, 400));
      end else if (r < 60) begin
        c = CMD_REMOVE;
        d = rand_time();
        // Usually remove a slot that is armed, so removals do real work.
        if ($urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, SLOTS - 1);
          for (int i = 0; i < SLOTS; i++) begin
            if (tracker.armed[(pick + i) % SLOTS]) begin
              s = SLOT_W'((pick + i) % SLOTS);
              break;
            end
          end
        end
      end else if (r < 95) begin
        c = CMD_TICK;
        d = rand_time();
      end else begin
        c = CMD_UNUSED;
        d = rand_time();
      end
      send_beat(c, s, d, wall_time);
    end else begin
      c = CMD_W'($urandom_range(0, 3));
      // A tick at the end of time flushes the far-off deadlines that noise
      // leaves behind, so slots keep coming free for well-formed traffic.
      if (c == CMD_TICK && $urandom_range(0, 1) == 0)
        send_beat(c, s, rand_time(), '1);
      else
        send_beat(c, s, rand_time(), rand_time());
    end
  endtask

  initial begin
    int tries;
    tracker     = new();
    cycles      = 0;
    beats_sent  = 0;
    busy_beats  = 0;
    wall_time   = 64'd3000;
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = CMD_TICK;
    slot        = '0;
    delay_ns    = '0;
    now         = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Commands that do nothing: a tick on an empty queue,
    // removing an idle slot and the unused command code.
    send_beat(CMD_TICK, 4'd0, 64'd0, 64'd500);
    send_beat(CMD_REMOVE, 4'd4, 64'd0, 64'd500);
    send_beat(CMD_UNUSED, 4'd2, 64'd7, 64'd500);

    // Register, then register the same slot again (ignored), a zero delay,
    // an equal deadline registered later, and a delay that wraps the
    // deadline to just before now, so the alarm saturates at zero.
    send_beat(CMD_ARM, 4'd0, 64'd100, 64'd1000);
    send_beat(CMD_ARM, 4'd0, 64'd5, 64'd1000);
    send_beat(CMD_ARM, 4'd15, 64'd0, 64'd1000);
    send_beat(CMD_ARM, 4'd5, 64'd100, 64'd1000);
    send_beat(CMD_ARM, 4'd7, '1, 64'd1000);
    send_beat(CMD_REMOVE, 4'd7, 64'd0, 64'd1000);

    // Fires slot 15, then 5 before 0 on the shared deadline, then a clear.
    send_beat(CMD_TICK, 4'd0, 64'd0, 64'd1100);

    // Arm every slot on one deadline; the tick then gives the longest burst:
    // sixteen expiries, newest registration first, and a clear.
    for (int i = 0; i < SLOTS; i++)
      send_beat(CMD_ARM, SLOT_W'(i), 64'd50, 64'd2000);
    send_beat(CMD_TICK, 4'd0, 64'd0, 64'd2050);
    wait_drained();

    // Random part, until the run has sent its full count of beats.
    tries = 0;
    while (beats_sent < TOTAL_BEATS && tries < 400) begin
      random_beat();
      tries++;
      if (tries % 32 == 0)
        wait_drained();
    end

    // Drain: every owed result back, the block idle, then a quiet stretch
    // in which any stray strobe would be caught as unexpected.
    start <= 1'b0;
    while (tracker.pending.size() != 0 || busy)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d command beats sent, %0d owed results, %0d results checked",
             beats_sent, busy_beats, tracker.checked);
    $display("summary: %0d slot expiries seen, %0d mismatches", tracker.expiries,
             tracker.errors);
    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
